// ----- hw/rtl/ftdr_pkg.sv -----
// shared constants, widths and sequencer states of the triangle depth raster
// no dependencies
`default_nettype none
package ftdr_pkg;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int XW            = $clog2(SCREEN_WIDTH);
    localparam int YW            = $clog2(SCREEN_HEIGHT);
    localparam int AW            = $clog2(PIXEL_COUNT);

    localparam int CW   = 10;  // vertex coordinate
    localparam int DW   = 16;  // depth
    localparam int COLW = 24;  // color
    localparam int IW   = 12;  // read index
    localparam int NW   = 13;  // pixel count
    localparam int UW   = 23;  // edge cross product
    localparam int MAW  = 24;  // multiplier operand a
    localparam int MBW  = 17;  // multiplier operand b
    localparam int ACCW = 42;  // depth numerator
    localparam int QW   = 17;  // interpolated depth

    localparam logic signed [DW-1:0] DEPTH_FAR = 16'sh8000;
    localparam logic [NW-1:0]        COUNT_MAX = 13'h1fff;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_RD, S_RD2, S_UZ0, S_UZ1, S_BOX,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_DIV, S_RES
    } t_state;
endpackage
`default_nettype wire

// ----- hw/rtl/ftdr_div.sv -----
// restoring signed divider for the interpolated depth, one quotient bit a cycle
// depends on ftdr_pkg; quotient magnitude is assumed below 2**QW
`default_nettype none
module ftdr_div
    import ftdr_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire signed [ACCW-1:0] i_num,
    input  wire signed [UW-1:0]   i_den,
    output logic                  o_done,
    output logic signed [QW-1:0]  o_quot
);
    localparam int RW = UW - 1;
    localparam int KW = $clog2(QW + 1);

    logic [RW-1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_den;
    logic [QW-1:0]   r_dq, n_dq;
    logic [KW-1:0]   r_cnt;
    logic            r_busy, r_neg, r_done;
    logic [ACCW-1:0] mag;
    logic [UW-1:0]   den_mag;
    logic [RW:0]     sh;

    always_comb begin
        mag     = i_num[ACCW-1] ? ACCW'(-i_num) : ACCW'(i_num);
        den_mag = i_den[UW-1] ? UW'(-i_den) : UW'(i_den);
        sh      = {r_rem, r_dq[QW-1]};
        if (sh >= {1'b0, r_den}) begin
            n_rem = RW'(sh - {1'b0, r_den});
            n_dq  = {r_dq[QW-2:0], 1'b1};
        end else begin
            n_rem = sh[RW-1:0];
            n_dq  = {r_dq[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // high part of the numerator is below the divisor by the range of the quotient
            r_rem <= mag[QW +: RW];
            r_dq  <= mag[QW-1:0];
            r_den <= den_mag[RW-1:0];
            r_neg <= i_num[ACCW-1] ^ i_den[UW-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? QW'(-$signed(r_dq)) : $signed(r_dq);
endmodule
`default_nettype wire

// ----- hw/rtl/flat_triangle_depth_raster.sv -----
// flat-color triangle rasterizer with depth and color stores, top level
// depends on ftdr_pkg and ftdr_div
// Each request gives one result. A draw runs the setup states S_UZ0, S_UZ1 and
// S_BOX (the two area products and the box) and loads the result in S_RES. In
// between it visits, per pixel of the screen-clamped bounding box, S_P0 to S_P4
// when the pixel is outside the triangle and S_P0 to S_DIV when it is inside:
// one shared 24x17 multiplier serves the seven products in S_P0 to S_P6, then
// the divider works out the 17 quotient bits. A read passes S_RD and S_RD2, a
// clear walks S_CLEAR over both stores; each also loads its result in S_RES. A
// result that is not taken holds the block in S_RES. After reset the block runs
// a clearing pass over both stores before it takes a request.
`default_nettype none
module flat_triangle_depth_raster
    import ftdr_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // v0_x, v0_y, v0_depth, v1_x, v1_y, v1_depth, v2_x, v2_y, v2_depth,
    // fill_color, read_index
    input  wire [143:0]  s_axis_tdata,
    input  wire [1:0]    s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // pixels_written, degenerate, read_color, read_depth, zero fill
    output logic [55:0]  m_axis_tdata
);
    t_state r_state, n_state;

    logic [1:0]             r_op;
    logic signed [CW-1:0]   r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [DW-1:0]   r_da, r_db, r_dc;
    logic [COLW-1:0]        r_color;
    logic [IW-1:0]          r_ridx;
    logic                   r_emit;
    logic [AW-1:0]          r_clr;
    logic signed [ACCW-1:0] r_acc;
    logic signed [UW-1:0]   r_uz, r_ux, r_uy;
    logic [XW-1:0]          r_px, r_x1;
    logic [YW-1:0]          r_py, r_y0, r_y1;
    logic [NW-1:0]          r_count;
    logic                   r_degen;
    logic [COLW-1:0]        r_rcolor;
    logic [DW-1:0]          r_rdepth;
    logic                   r_ovalid;
    logic [55:0]            r_odata;

    logic [DW-1:0]   depth_mem [PIXEL_COUNT];
    logic [COLW-1:0] color_mem [PIXEL_COUNT];
    logic [DW-1:0]   r_mem_d;
    logic [COLW-1:0] r_mem_c;

    logic                    accept;
    logic signed [CW:0]      ex, fx, ey, fy, gx, gy;
    logic signed [CW:0]      xmin, xmax, ymin, ymax;
    logic signed [UW+1:0]    wa;
    logic                    covered;
    logic signed [MAW-1:0]   ma;
    logic signed [MBW-1:0]   mb;
    logic signed [ACCW-1:0]  prod;
    logic                    div_start, div_done;
    logic signed [QW-1:0]    quot;
    logic [AW-1:0]           rd_addr, pix_addr;
    logic                    last_pix;
    logic                    zpass;
    logic [AW-1:0]           ridx_a;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    function automatic logic signed [CW:0] min3(input logic signed [CW-1:0] a, b, c);
        logic signed [CW-1:0] m;
        m = (a < b) ? a : b;
        m = (m < c) ? m : c;
        return (CW+1)'(m);
    endfunction

    function automatic logic signed [CW:0] max3(input logic signed [CW-1:0] a, b, c);
        logic signed [CW-1:0] m;
        m = (a > b) ? a : b;
        m = (m > c) ? m : c;
        return (CW+1)'(m);
    endfunction

    always_comb begin
        ex   = (CW+1)'(r_cx) - (CW+1)'(r_ax);
        fx   = (CW+1)'(r_bx) - (CW+1)'(r_ax);
        ey   = (CW+1)'(r_cy) - (CW+1)'(r_ay);
        fy   = (CW+1)'(r_by) - (CW+1)'(r_ay);
        gx   = (CW+1)'(r_ax) - $signed({1'b0, (CW)'(r_px)});
        gy   = (CW+1)'(r_ay) - $signed({1'b0, (CW)'(r_py)});
        xmin = min3(r_ax, r_bx, r_cx);
        xmax = max3(r_ax, r_bx, r_cx);
        ymin = min3(r_ay, r_by, r_cy);
        ymax = max3(r_ay, r_by, r_cy);
        wa   = (UW+2)'(r_uz) - (UW+2)'(r_ux) - (UW+2)'(r_uy);
        if (r_uz > 0)
            covered = !(wa < 0 || r_ux < 0 || r_uy < 0);
        else
            covered = !(wa > 0 || r_ux > 0 || r_uy > 0);
        pix_addr = AW'(r_py) * AW'(SCREEN_WIDTH) + AW'(r_px);
        last_pix = (r_py == r_y1) && (r_px == r_x1);
        ridx_a   = r_ridx[AW-1:0];
        zpass    = quot >= $signed({r_mem_d[DW-1], r_mem_d});
    end

    // shared multiplier operand selection
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_UZ0: begin ma = MAW'(ex); mb = MBW'(fy); end
            S_UZ1: begin ma = MAW'(fx); mb = MBW'(ey); end
            S_P0:  begin ma = MAW'(fx); mb = MBW'(gy); end
            S_P1:  begin ma = MAW'(gx); mb = MBW'(fy); end
            S_P2:  begin ma = MAW'(gx); mb = MBW'(ey); end
            S_P3:  begin ma = MAW'(ex); mb = MBW'(gy); end
            S_P4:  begin ma = wa[MAW-1:0]; mb = MBW'(r_da); end
            S_P5:  begin ma = MAW'(r_uy); mb = MBW'(r_db); end
            S_P6:  begin ma = MAW'(r_ux); mb = MBW'(r_dc); end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ACCW'(ma * mb);
    end

    assign div_start = (r_state == S_P6);

    ftdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc + prod),
        .i_den   (r_uz),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        OP_DRAW:  n_state = S_UZ0;
                        OP_READ:  n_state = S_RD;
                        OP_CLEAR: n_state = S_CLEAR;
                        default:  n_state = S_RES;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_clr == AW'(PIXEL_COUNT - 1))
                    n_state = r_emit ? S_RES : S_IDLE;
            end
            S_RD:  n_state = S_RD2;
            S_RD2: n_state = S_RES;
            S_UZ0: n_state = S_UZ1;
            S_UZ1: n_state = S_BOX;
            S_BOX: begin
                if (r_uz == 0 || xmax < 0 || xmin > (CW+1)'(SCREEN_WIDTH - 1) ||
                    ymax < 0 || ymin > (CW+1)'(SCREEN_HEIGHT - 1))
                    n_state = S_RES;
                else
                    n_state = S_P0;
            end
            S_P0: n_state = S_P1;
            S_P1: n_state = S_P2;
            S_P2: n_state = S_P3;
            S_P3: n_state = S_P4;
            S_P4: begin
                if (covered)
                    n_state = S_P5;
                else
                    n_state = last_pix ? S_RES : S_P0;
            end
            S_P5: n_state = S_P6;
            S_P6: n_state = S_DIV;
            S_DIV: begin
                if (div_done)
                    n_state = last_pix ? S_RES : S_P0;
            end
            S_RES: begin
                if (!r_ovalid || m_axis_tready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // store read address
    always_comb begin
        case (r_state)
            S_RD:    rd_addr = ridx_a;
            default: rd_addr = pix_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_CLEAR;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit   <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR)
                r_clr <= r_clr + 1'b1;
            if (accept)
                r_emit <= 1'b1;
            if (r_state == S_RES && (!r_ovalid || m_axis_tready))
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;
        end
    end

    // request capture and datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= s_axis_tuser;
            r_ax     <= s_axis_tdata[9:0];
            r_ay     <= s_axis_tdata[19:10];
            r_da     <= s_axis_tdata[35:20];
            r_bx     <= s_axis_tdata[45:36];
            r_by     <= s_axis_tdata[55:46];
            r_db     <= s_axis_tdata[71:56];
            r_cx     <= s_axis_tdata[81:72];
            r_cy     <= s_axis_tdata[91:82];
            r_dc     <= s_axis_tdata[107:92];
            r_color  <= s_axis_tdata[131:108];
            r_ridx   <= s_axis_tdata[143:132];
            r_count  <= '0;
            r_degen  <= 1'b0;
            r_rcolor <= '0;
            r_rdepth <= '0;
        end
        case (r_state)
            S_UZ0: r_acc <= prod;
            S_UZ1: r_uz  <= UW'(r_acc - prod);
            S_BOX: begin
                r_degen <= (r_uz == 0);
                r_x1 <= (xmax > (CW+1)'(SCREEN_WIDTH - 1)) ? XW'(SCREEN_WIDTH - 1) :
                        (xmax < 0) ? '0 : xmax[XW-1:0];
                r_y0 <= (ymin < 0) ? '0 : (ymin > (CW+1)'(SCREEN_HEIGHT - 1)) ?
                        YW'(SCREEN_HEIGHT - 1) : ymin[YW-1:0];
                r_y1 <= (ymax > (CW+1)'(SCREEN_HEIGHT - 1)) ? YW'(SCREEN_HEIGHT - 1) :
                        (ymax < 0) ? '0 : ymax[YW-1:0];
                r_px <= (xmin < 0) ? '0 : xmin[XW-1:0];
                r_py <= (ymin < 0) ? '0 : ymin[YW-1:0];
            end
            S_P0: r_acc <= prod;
            S_P1: r_ux  <= UW'(r_acc - prod);
            S_P2: r_acc <= prod;
            S_P3: r_uy  <= UW'(r_acc - prod);
            S_P4: r_acc <= prod;
            S_P5: r_acc <= r_acc + prod;
            S_RD2: begin
                if ((IW+1)'(r_ridx) < (IW+1)'(PIXEL_COUNT)) begin
                    r_rcolor <= r_mem_c;
                    r_rdepth <= r_mem_d;
                end
            end
            default: ;
        endcase
        // advance the scan, column-major
        if ((r_state == S_P4 && !covered) || (r_state == S_DIV && div_done)) begin
            if (r_py == r_y1) begin
                r_py <= r_y0;
                r_px <= r_px + 1'b1;
            end else begin
                r_py <= r_py + 1'b1;
            end
        end
        if (r_state == S_DIV && div_done && zpass && r_count != COUNT_MAX)
            r_count <= r_count + 1'b1;
        if (r_state == S_RES && (!r_ovalid || m_axis_tready))
            r_odata <= (r_op == OP_DRAW) ?
                {2'b00, 16'h0, 24'h0, r_degen, r_count} :
                (r_op == OP_READ) ? {2'b00, r_rdepth, r_rcolor, 1'b0, 13'h0} : '0;
    end

    // depth and color stores
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            depth_mem[r_clr] <= DEPTH_FAR;
            color_mem[r_clr] <= '0;
        end else if (r_state == S_DIV && div_done && zpass) begin
            depth_mem[pix_addr] <= quot[DW-1:0];
            color_mem[pix_addr] <= r_color;
        end
        r_mem_d <= depth_mem[rd_addr];
        r_mem_c <= color_mem[rd_addr];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
`default_nettype wire
